### rtl/tag_pkg.sv
// tag_pkg: shared constants, register codes and helpers for the transpose
// address generator. No dependencies.
package tag_pkg;

    localparam int MAX_RANK_DEF   = 8;
    localparam int INDEX_BITS_DEF = 32;
    localparam int DIM_BITS_DEF   = 8;

    // restoring division steps done in one pipeline stage
    localparam int DIGIT_STEPS = 8;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int RANK_BITS     = 4;
    localparam int MAP_BITS      = 24;
    localparam int MAP_ENT_BITS  = 3;
    localparam int DIM_SLOT_BITS = 8;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SOURCE_RANK = 3'd0,
        REG_RESULT_RANK = 3'd1,
        REG_SOURCE_DIMS = 3'd2,
        REG_RESULT_DIMS = 3'd3,
        REG_AXIS_MAP    = 3'd4
    } cfg_reg_t;

    localparam logic [RANK_BITS-1:0]     RANK_RST = 4'd1;
    localparam logic [CFG_DATA_BITS-1:0] DIMS_RST = 64'h0101_0101_0101_0101;
    localparam logic [MAP_BITS-1:0]      MAP_RST  = 24'd0;

    // rank 0 reads as 1, anything above max_rank reads as max_rank
    function automatic logic [RANK_BITS-1:0] eff_rank(
        input logic [RANK_BITS-1:0] r,
        input logic [RANK_BITS-1:0] max_rank
    );
        logic [RANK_BITS-1:0] res;
        if (r == '0)
            res = RANK_BITS'(1);
        else if (r > max_rank)
            res = max_rank;
        else
            res = r;
        return res;
    endfunction

endpackage

### rtl/tag_div_stage.sv
// tag_div_stage: one register stage of the mixed-radix split, DIGIT_STEPS bits of
// restoring division of the running index by one result axis length.
// Depends on tag_pkg.
module tag_div_stage
    import tag_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF,
    parameter int QUO_BITS = 32,
    parameter int AXIS     = 0,
    parameter bit LAST_SUB = 1'b0
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         active,
    input  logic [DIM_BITS-1:0]          dim,
    input  logic                         valid_in,
    input  logic [QUO_BITS-1:0]          quo_in,
    input  logic [DIM_BITS-1:0]          prem_in,
    input  logic [MAX_RANK*DIM_BITS-1:0] coords_in,
    output logic                         valid_out,
    output logic [QUO_BITS-1:0]          quo_out,
    output logic [DIM_BITS-1:0]          prem_out,
    output logic [MAX_RANK*DIM_BITS-1:0] coords_out
);

    logic                         valid_reg;
    logic [QUO_BITS-1:0]          quo_reg, quo_next;
    logic [DIM_BITS-1:0]          prem_reg, prem_next;
    logic [MAX_RANK*DIM_BITS-1:0] coords_reg, coords_next;
    logic [DIM_BITS:0]            trial;
    logic                         work;

    assign work = active && (dim != '0);

    always_comb
    begin
        quo_next    = quo_in;
        prem_next   = prem_in;
        coords_next = coords_in;
        trial       = '0;
        if (work)
        begin
            for (int step = 0; step < DIGIT_STEPS; step++)
            begin
                trial    = {prem_next, quo_next[QUO_BITS-1]};
                quo_next = {quo_next[QUO_BITS-2:0], 1'b0};
                if (trial >= {1'b0, dim})
                begin
                    trial       = trial - {1'b0, dim};
                    quo_next[0] = 1'b1;
                end
                prem_next = trial[DIM_BITS-1:0];
            end
            if (LAST_SUB)
            begin
                // remainder is this axis coordinate, start clean for the next axis
                coords_next[AXIS*DIM_BITS +: DIM_BITS] = prem_next;
                prem_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg    <= quo_next;
            prem_reg   <= prem_next;
            coords_reg <= coords_next;
        end
    end

    assign valid_out  = valid_reg;
    assign quo_out    = quo_reg;
    assign prem_out   = prem_reg;
    assign coords_out = coords_reg;

endmodule

### rtl/tag_fold_stage.sv
// tag_fold_stage: one Horner step of folding the source coordinates back into
// a linear index, acc = acc * length + coordinate for one source axis.
// Depends on tag_pkg.
module tag_fold_stage
    import tag_pkg::*;
#(
    parameter int MAX_RANK   = MAX_RANK_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int AXIS       = 0
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [RANK_BITS-1:0]         src_rank,
    input  logic [RANK_BITS-1:0]         res_rank,
    input  logic [DIM_BITS-1:0]          dim,
    input  logic [MAP_ENT_BITS-1:0]      map_ent,
    input  logic                         valid_in,
    input  logic                         oor_in,
    input  logic [INDEX_BITS-1:0]        acc_in,
    input  logic [MAX_RANK*DIM_BITS-1:0] coords,
    output logic                         valid_out,
    output logic                         oor_out,
    output logic [INDEX_BITS-1:0]        acc_out,
    output logic [MAX_RANK*DIM_BITS-1:0] coords_out
);

    logic                         valid_reg;
    logic                         oor_reg;
    logic [INDEX_BITS-1:0]        acc_reg, acc_next;
    logic [MAX_RANK*DIM_BITS-1:0] coords_reg;
    logic [DIM_BITS-1:0]          coord;
    logic [INDEX_BITS+DIM_BITS-1:0] prod;

    // unmapped or out-of-rank result axis gives coordinate zero
    always_comb
    begin
        coord = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if ((map_ent == MAP_ENT_BITS'(k)) && (RANK_BITS'(k) < res_rank))
                coord = coords[k*DIM_BITS +: DIM_BITS];
        end
    end

    assign prod = acc_in * dim;

    always_comb
    begin
        if (RANK_BITS'(AXIS) < src_rank)
            acc_next = prod[INDEX_BITS-1:0] + INDEX_BITS'(coord);
        else
            acc_next = acc_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor_reg    <= oor_in;
            acc_reg    <= acc_next;
            coords_reg <= coords;
        end
    end

    assign valid_out  = valid_reg;
    assign oor_out    = oor_reg;
    assign acc_out    = acc_reg;
    assign coords_out = coords_reg;

endmodule

### rtl/transpose_address_generator_top.sv
// transpose_address_generator_top: configuration registers, the division
// pipeline over result axes, the fold pipeline over source axes, output register.
// Depends on tag_pkg, tag_div_stage, tag_fold_stage.
//
//   channel   signals                                         direction
//   input     in_valid / in_ready, result_index               in
//   output    out_valid / out_ready, source_index, out_of_range  out
//   config    cfg_wr_en, cfg_addr, cfg_wdata                  in
//
// the pipeline holds division stages of eight restoring steps each for every
// result axis, one multiply-add stage per source axis, then the output register.
// one item per cycle is accepted while the output is free or being taken.
// a stall at the output freezes the whole pipeline; nothing is dropped.
// reset clears the valid bits and loads the configuration reset values.
module transpose_address_generator_top
    import tag_pkg::*;
#(
    parameter int MAX_RANK   = MAX_RANK_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [INDEX_BITS-1:0]    result_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [INDEX_BITS-1:0]    source_index,
    output logic                     out_of_range
);

    localparam int DIV_SUBS = (INDEX_BITS + DIGIT_STEPS - 1) / DIGIT_STEPS;
    localparam int QUO_BITS = DIV_SUBS * DIGIT_STEPS;
    localparam int NDIV     = MAX_RANK * DIV_SUBS;
    localparam int CW       = MAX_RANK * DIM_BITS;

    logic [RANK_BITS-1:0]     source_rank_reg;
    logic [RANK_BITS-1:0]     result_rank_reg;
    logic [CFG_DATA_BITS-1:0] source_dims_reg;
    logic [CFG_DATA_BITS-1:0] result_dims_reg;
    logic [MAP_BITS-1:0]      axis_map_reg;

    logic [RANK_BITS-1:0] sr, rr;
    logic                 en;
    logic                 zero_dim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_rank_reg <= RANK_RST;
            result_rank_reg <= RANK_RST;
            source_dims_reg <= DIMS_RST;
            result_dims_reg <= DIMS_RST;
            axis_map_reg    <= MAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SOURCE_RANK: source_rank_reg <= cfg_wdata[RANK_BITS-1:0];
                REG_RESULT_RANK: result_rank_reg <= cfg_wdata[RANK_BITS-1:0];
                REG_SOURCE_DIMS: source_dims_reg <= cfg_wdata;
                REG_RESULT_DIMS: result_dims_reg <= cfg_wdata;
                REG_AXIS_MAP:    axis_map_reg    <= cfg_wdata[MAP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign sr = eff_rank(source_rank_reg, RANK_BITS'(MAX_RANK));
    assign rr = eff_rank(result_rank_reg, RANK_BITS'(MAX_RANK));

    // a zero-length result axis makes the result empty
    always_comb
    begin
        zero_dim = 1'b0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if ((RANK_BITS'(k) < rr) &&
                (result_dims_reg[k*DIM_SLOT_BITS +: DIM_BITS] == '0))
                zero_dim = 1'b1;
        end
    end

    logic                out_valid_reg;
    logic [INDEX_BITS-1:0] source_index_reg;
    logic                out_of_range_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // division chain
    logic                div_valid  [0:NDIV];
    logic [QUO_BITS-1:0] div_quo    [0:NDIV];
    logic [DIM_BITS-1:0] div_prem   [0:NDIV];
    logic [CW-1:0]       div_coords [0:NDIV];

    assign div_valid[0]  = in_valid;
    assign div_quo[0]    = QUO_BITS'(result_index);
    assign div_prem[0]   = '0;
    assign div_coords[0] = '0;

    for (genvar s = 0; s < NDIV; s++)
    begin : g_div
        localparam int AX = s / DIV_SUBS;
        tag_div_stage #(
            .MAX_RANK (MAX_RANK),
            .DIM_BITS (DIM_BITS),
            .QUO_BITS (QUO_BITS),
            .AXIS     (AX),
            .LAST_SUB ((s % DIV_SUBS) == (DIV_SUBS - 1))
        ) u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .active     (RANK_BITS'(AX) < rr),
            .dim        (result_dims_reg[AX*DIM_SLOT_BITS +: DIM_BITS]),
            .valid_in   (div_valid[s]),
            .quo_in     (div_quo[s]),
            .prem_in    (div_prem[s]),
            .coords_in  (div_coords[s]),
            .valid_out  (div_valid[s+1]),
            .quo_out    (div_quo[s+1]),
            .prem_out   (div_prem[s+1]),
            .coords_out (div_coords[s+1])
        );
    end

    // fold chain, top source axis first
    logic                  fold_valid  [0:MAX_RANK];
    logic                  fold_oor    [0:MAX_RANK];
    logic [INDEX_BITS-1:0] fold_acc    [0:MAX_RANK];
    logic [CW-1:0]         fold_coords [0:MAX_RANK];

    // leftover quotient means the index is past the result size
    assign fold_valid[0]  = div_valid[NDIV];
    assign fold_oor[0]    = (div_quo[NDIV] != '0) || zero_dim;
    assign fold_acc[0]    = '0;
    assign fold_coords[0] = div_coords[NDIV];

    for (genvar f = 0; f < MAX_RANK; f++)
    begin : g_fold
        localparam int AX = MAX_RANK - 1 - f;
        tag_fold_stage #(
            .MAX_RANK   (MAX_RANK),
            .DIM_BITS   (DIM_BITS),
            .INDEX_BITS (INDEX_BITS),
            .AXIS       (AX)
        ) u_fold (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .src_rank   (sr),
            .res_rank   (rr),
            .dim        (source_dims_reg[AX*DIM_SLOT_BITS +: DIM_BITS]),
            .map_ent    (axis_map_reg[AX*MAP_ENT_BITS +: MAP_ENT_BITS]),
            .valid_in   (fold_valid[f]),
            .oor_in     (fold_oor[f]),
            .acc_in     (fold_acc[f]),
            .coords     (fold_coords[f]),
            .valid_out  (fold_valid[f+1]),
            .oor_out    (fold_oor[f+1]),
            .acc_out    (fold_acc[f+1]),
            .coords_out (fold_coords[f+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fold_valid[MAX_RANK];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_of_range_reg <= fold_oor[MAX_RANK];
            source_index_reg <= fold_oor[MAX_RANK] ? '0 : fold_acc[MAX_RANK];
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = source_index_reg;
    assign out_of_range = out_of_range_reg;

endmodule

### rtl/tag_checker.sv
// tag_checker: port-level assertions for the transpose address generator,
// bound to the top level. Depends on tag_pkg and transpose_address_generator_top.
module tag_checker
    import tag_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [INDEX_BITS-1:0] source_index,
    input logic                  out_of_range
);

    // a flagged item never carries an address
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (source_index == '0))
        else $error("out_of_range item with nonzero source_index");

    // input side opens whenever the output is free or being taken
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("in_ready low while output can move");

    // a held output keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(source_index) && $stable(out_of_range)))
        else $error("stalled output item changed");

endmodule

bind transpose_address_generator_top tag_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_tag_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_index (source_index),
    .out_of_range (out_of_range)
);

### tb/transpose_address_checker.sv
// transpose_address_checker: watches the config port and both item channels of the
// transpose address generator, predicts each source index and compares in order.
// Depends on tag_pkg for the register codes.
`timescale 1ns / 1ps

module transpose_address_checker
    import tag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] result_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] source_index,
    input  logic        out_of_range,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [31:0] src;
        logic        oor;
    } address_t;

    logic [3:0]  src_rank, res_rank;
    logic [63:0] src_dims, res_dims;
    logic [23:0] amap;
    address_t    addr_q[$];

    function automatic int clamp_rank(logic [3:0] r);
        int v;
        v = r;
        if (v < 1) v = 1;
        if (v > 8) v = 8;
        return v;
    endfunction

    function automatic address_t source_address(logic [31:0] ri);
        int          rr, sr, a;
        logic [63:0] size, rem, stride, acc, d;
        logic [63:0] coord[8];
        address_t    r;
        rr = clamp_rank(res_rank);
        sr = clamp_rank(src_rank);
        size = 64'd1;
        for (int i = 0; i < 8; i++) coord[i] = '0;
        for (int i = 0; i < rr; i++) size = size * 64'(res_dims[i*8 +: 8]);
        if (64'(ri) >= size) begin
            r.src = '0;
            r.oor = 1'b1;
            return r;
        end
        rem = 64'(ri);
        for (int i = 0; i < rr; i++) begin
            d = 64'(res_dims[i*8 +: 8]);
            if (d != 0) begin
                coord[i] = rem % d;
                rem = rem / d;
            end
        end
        acc = '0;
        stride = 64'd1;
        for (int j = 0; j < sr; j++) begin
            a = amap[j*3 +: 3];
            // map entry beyond the result rank picks coordinate zero
            if (a < rr) acc = acc + coord[a] * stride;
            stride = stride * 64'(src_dims[j*8 +: 8]);
        end
        r.src = acc[31:0];
        r.oor = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        address_t e;
        if (!rst_n) begin
            src_rank   <= 4'd1;
            res_rank   <= 4'd1;
            src_dims   <= 64'h0101_0101_0101_0101;
            res_dims   <= 64'h0101_0101_0101_0101;
            amap       <= '0;
            mismatches <= 0;
            pending    <= 0;
            addr_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SOURCE_RANK: src_rank <= cfg_wdata[3:0];
                    REG_RESULT_RANK: res_rank <= cfg_wdata[3:0];
                    REG_SOURCE_DIMS: src_dims <= cfg_wdata;
                    REG_RESULT_DIMS: res_dims <= cfg_wdata;
                    REG_AXIS_MAP:    amap     <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) addr_q.push_back(source_address(result_index));
            if (out_valid && out_ready) begin
                if (addr_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected item src=%h oor=%b",
                                 $realtime, source_index, out_of_range);
                    mismatches <= mismatches + 1;
                end else begin
                    e = addr_q.pop_front();
                    if (e.src !== source_index || e.oor !== out_of_range) begin
                        if (mismatches < 10)
                            $display("%0t: expected src=%h oor=%b, got src=%h oor=%b",
                                     $realtime, e.src, e.oor, source_index, out_of_range);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= addr_q.size();
        end
    end

endmodule

### tb/transpose_address_generator_top_test.sv
// transpose_address_generator_top_test: stimulus and verdict for the transpose
// address generator. Depends on tag_pkg, the block and transpose_address_checker.
`timescale 1ns / 1ps

module transpose_address_generator_top_test;
    import tag_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int         DRAIN      = 60;
    localparam int         CYCLE_CAP  = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] result_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] source_index;
    logic        out_of_range;
    int          mismatches, pending;
    int          cycles = 0;
    bit          no_gaps = 0;
    int          stall_left = 0;
    logic [63:0] cur_size;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    transpose_address_generator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .result_index(result_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .source_index(source_index), .out_of_range(out_of_range)
    );

    transpose_address_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .result_index(result_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .source_index(source_index), .out_of_range(out_of_range),
        .mismatches(mismatches), .pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= no_gaps || ($urandom_range(0, 3) != 0);
            stall_left <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input logic [31:0] v);
        int   g;
        logic rdy;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid     <= 1'b1;
        result_index <= v;
        // ready is looked at mid-cycle, where it holds the value the next edge sees
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [63:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge clk);
    endtask

    // waits for the block to drain, then loads a full configuration
    task automatic configure(input logic [3:0] sr, input logic [3:0] rr,
                             input logic [63:0] sd, input logic [63:0] rd,
                             input logic [23:0] am);
        int n;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        reg_write(REG_SOURCE_RANK, {$urandom, 28'd0, sr} & 64'hFFFF_FFFF_0000_000F
                  | {$urandom, 32'd0} & 64'h0 | 64'(sr) | {$urandom, 32'h0} & 64'hFFFF_FFF0_0000_0000);
        reg_write(REG_RESULT_RANK, {$urandom, 28'd0, rr});
        reg_write(REG_SOURCE_DIMS, sd);
        reg_write(REG_RESULT_DIMS, rd);
        reg_write(REG_AXIS_MAP, {$urandom, 8'd0, am});
        if ($urandom_range(0, 3) == 0)
            reg_write(REG_UNUSED + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        n = (rr == 0) ? 1 : (rr > 8) ? 8 : rr;
        cur_size = 64'd1;
        for (int i = 0; i < n; i++) cur_size = cur_size * 64'(rd[i*8 +: 8]);
    endtask

    function automatic logic [31:0] pick_index();
        logic [63:0] top;
        if (cur_size != 0 && $urandom_range(0, 3) != 0) begin
            top = cur_size - 1;
            if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
            return $urandom_range(0, int'(top[31:0]) ) ;
        end
        return $urandom;
    endfunction

    function automatic logic [7:0] rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8'd0;
        if (r < 12) return 8'($urandom);
        if (r < 15) return 8'd255;
        return 8'($urandom_range(1, 5));
    endfunction

    initial
    begin
        logic [3:0]  sr, rr;
        logic [63:0] sd, rd;
        logic [23:0] am;
        int          er, count;
        cur_size = 64'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset configuration: size one
        send(32'd0);
        send(32'd1);
        send(32'hFFFF_FFFF);

        // 3d reversal, result 2x3x4
        configure(4'd3, 4'd3, 64'h020304, 64'h040302, 24'o012);
        send(32'd0); send(32'd5); send(32'd23); send(32'd24); send(32'h8000_0000);

        // main diagonal of a 5x5 into a 5-long vector
        configure(4'd2, 4'd1, 64'h0505, 64'h05, 24'o00);
        send(32'd3); send(32'd4); send(32'd5);

        // zero-length result axis flags everything
        configure(4'd2, 4'd2, 64'h0303, 64'h0300, 24'o10);
        send(32'd0); send(32'd7);

        // rank zero and rank fifteen, map entries past the result rank
        configure(4'd0, 4'd15, {8{8'hFF}}, {8{8'hFF}}, 24'o76543210);
        send(32'hFFFF_FFFF); send(32'h1234_5678); send(32'd0);
        configure(4'd15, 4'd0, {8{8'hFF}}, 64'hFF, 24'o77777777);
        send(32'd254); send(32'd255);
        configure(4'd8, 4'd2, {8{8'hFF}}, 64'hFFFF, 24'o10101010);
        send(32'd65534); send(32'hFFFE);

        count = 0;
        while (count < 1230) begin
            sr = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
            rr = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
            er = (rr == 0) ? 1 : (rr > 8) ? 8 : rr;
            for (int i = 0; i < 8; i++) begin
                sd[i*8 +: 8] = rand_dim();
                rd[i*8 +: 8] = rand_dim();
                am[i*3 +: 3] = ($urandom_range(0, 7) == 0) ? 3'($urandom)
                                                           : 3'($urandom_range(0, er - 1));
            end
            configure(sr, rr, sd, rd, am);
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 30; k++) send(pick_index());
            count += 30;
        end
        no_gaps = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
